// ----- hw/rtl/dfs_edge_classifier_core_macros.svh -----
// ----------------------------------------------------------------------------
// DFS edge classifier assertion macros
// Same-cycle-implication and next-cycle-implication checks, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DFS_EDGE_CLASSIFIER_CORE_MACROS_SVH
`define DFS_EDGE_CLASSIFIER_CORE_MACROS_SVH

// cons must hold in the same cycle as ante
`define DFS_EC_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define DFS_EC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/dfs_ec_pkg.sv -----
// ----------------------------------------------------------------------------
// DFS edge classifier package
// Widths, codes, controller states and the controller/datapath command set.
// ----------------------------------------------------------------------------
package dfs_ec_pkg;

  localparam int MAX_NODES     = 1024;
  localparam int DEF_MAX_EDGES = 2048;
  localparam int NODE_W        = 10;
  localparam int CNT_W         = 11;
  localparam int KIND_W        = 4;

  localparam logic [CNT_W-1:0] NODE_CNT_RST = CNT_W'(MAX_NODES);

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_STEP    = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_CLEAR   = 2'd3
  } act_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK    = 4'd0,
    KIND_START  = 4'd1,
    KIND_TREE   = 4'd2,
    KIND_BACK   = 4'd3,
    KIND_PARENT = 4'd4,
    KIND_CROSS  = 4'd5,
    KIND_FINISH = 4'd6,
    KIND_DONE   = 4'd7,
    KIND_REJECT = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    MARK_UNVISITED = 2'd0,
    MARK_FINISHED  = 2'd1,
    MARK_EXPLORED  = 2'd2
  } mark_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_BEGIN,
    OP_CLR,
    OP_SCAN_RD,
    OP_SCAN_NEXT,
    OP_DONE,
    OP_START_RD,
    OP_START_WR,
    OP_TOP_RD,
    OP_TOP,
    OP_EDGE,
    OP_CLASSIFY,
    OP_LD_RD,
    OP_LD_W1,
    OP_LD_W2
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BEGIN,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_START_RD,
    ST_START_WR,
    ST_TOP_RD,
    ST_TOP,
    ST_EDGE,
    ST_CLASSIFY,
    ST_LD_RD,
    ST_LD_W1,
    ST_LD_W2,
    ST_POST,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    act_t act;
    logic bad_load;
    logic depth_zero;
    logic sweep_end;
    logic mark_zero;
    logic cur_nil;
    logic clr_last;
    logic side;
  } dp_status_t;

endpackage

// ----- hw/rtl/dfs_ec_if.sv -----
// ----------------------------------------------------------------------------
// DFS edge classifier channels
// Valid/ready channels for commands, results and the node count register.
// ----------------------------------------------------------------------------
interface dfs_ec_in_if
  import dfs_ec_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  modport source (output valid, action, node_a, node_b, input ready);
  modport sink (input valid, action, node_a, node_b, output ready);
endinterface

interface dfs_ec_out_if
  import dfs_ec_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [NODE_W-1:0] from_node;
  logic [NODE_W-1:0] to_node;
  logic [CNT_W-1:0]  component;
  logic              walk_done;

  modport source (output valid, kind, from_node, to_node, component, walk_done,
                  input ready);
  modport sink (input valid, kind, from_node, to_node, component, walk_done,
                output ready);
endinterface

interface dfs_ec_cfg_if
  import dfs_ec_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] node_count;

  modport source (output valid, node_count, input ready);
  modport sink (input valid, node_count, output ready);
endinterface

// ----- hw/rtl/dfs_ec_datapath.sv -----
// ----------------------------------------------------------------------------
// DFS edge classifier datapath
// Edge slot stores, list ends, marks, parents, walk stack and result registers.
// ----------------------------------------------------------------------------
module dfs_ec_datapath
  import dfs_ec_pkg::*;
#(
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_op_t            op,
  output dp_status_t        status,
  input  logic [1:0]        in_action,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_node_count,
  input  logic              out_load,
  output logic [KIND_W-1:0] out_kind,
  output logic [NODE_W-1:0] out_from_node,
  output logic [NODE_W-1:0] out_to_node,
  output logic [CNT_W-1:0]  out_component,
  output logic              out_walk_done
);

  localparam int SLOTS = 2 * MAX_EDGES;
  localparam int SAW   = $clog2(SLOTS);
  localparam int SW    = $clog2(SLOTS + 1);
  localparam int FW    = $clog2(MAX_EDGES + 1);
  localparam logic [SW-1:0] NIL_SLOT = SW'(SLOTS);

  logic [NODE_W-1:0] tg_mem [SLOTS];
  logic [SW-1:0]     lk_mem [SLOTS];
  logic [SW-1:0]     hd_mem [MAX_NODES];
  logic [SW-1:0]     tl_mem [MAX_NODES];
  mark_t             mk_mem [MAX_NODES];
  logic [NODE_W-1:0] pa_mem [MAX_NODES];
  logic [NODE_W-1:0] sn_mem [MAX_NODES];
  logic [SW-1:0]     sc_mem [MAX_NODES];

  logic [NODE_W-1:0] tg_q, pa_q, sn_q;
  logic [SW-1:0]     lk_q, hd_q, tl_q, sc_q;
  mark_t             mk_q;

  logic tg_we, lk_we, hd_we, tl_we, mk_we, pa_we, sn_we, sc_we;
  logic tg_re, lk_re, hd_re, tl_re, mk_re, pa_re, sn_re, sc_re;
  logic [SAW-1:0]    tg_wa, lk_wa, tg_ra;
  logic [NODE_W-1:0] hd_wa, tl_wa, mk_wa, pa_wa, sn_wa, sc_wa;
  logic [NODE_W-1:0] hd_ra, tl_ra, mk_ra, pa_ra, sn_ra;
  logic [NODE_W-1:0] tg_wd, pa_wd, sn_wd;
  logic [SW-1:0]     lk_wd, hd_wd, tl_wd, sc_wd;
  mark_t             mk_wd;

  logic [CNT_W-1:0]  node_count_r;
  act_t              act_r;
  logic [NODE_W-1:0] a_r, b_r, s_r, n_r;
  logic [CNT_W-1:0]  depth_r, sweep_r, comp_r;
  logic [FW-1:0]     fill_r;
  logic [NODE_W-1:0] clr_idx_r;
  logic              clr_edges_r, side_r;
  kind_t             kind_r;
  logic [NODE_W-1:0] from_r, to_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [NODE_W-1:0] out_from_r, out_to_r;
  logic [CNT_W-1:0]  out_comp_r;
  logic              out_done_r;

  logic [CNT_W-1:0]  eff_cnt, depth_m1;
  logic [NODE_W-1:0] top_idx, push_idx, end_node, other_node;
  logic [SAW-1:0]    slot_a;
  logic [SW-1:0]     slot_v;
  logic              tail_nil, push_ok;

  assign eff_cnt    = (node_count_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_r;
  assign depth_m1   = depth_r - CNT_W'(1);
  assign top_idx    = depth_m1[NODE_W-1:0];
  assign push_idx   = depth_r[NODE_W-1:0];
  assign end_node   = side_r ? b_r : a_r;
  assign other_node = side_r ? a_r : b_r;
  assign slot_a     = SAW'({fill_r, side_r});
  assign slot_v     = SW'({fill_r, side_r});
  assign tail_nil   = tl_q >= NIL_SLOT;
  assign push_ok    = (mk_q == MARK_UNVISITED) && (depth_r < CNT_W'(MAX_NODES));

  assign status.act        = act_r;
  assign status.bad_load   = ({1'b0, a_r} >= eff_cnt) || ({1'b0, b_r} >= eff_cnt) ||
                             (fill_r == FW'(MAX_EDGES));
  assign status.depth_zero = depth_r == '0;
  assign status.sweep_end  = sweep_r >= eff_cnt;
  assign status.mark_zero  = mk_q == MARK_UNVISITED;
  assign status.cur_nil    = sc_q >= NIL_SLOT;
  assign status.clr_last   = clr_idx_r == NODE_W'(MAX_NODES - 1);
  assign status.side       = side_r;

  always_comb begin
    tg_we = 1'b0; lk_we = 1'b0; hd_we = 1'b0; tl_we = 1'b0;
    mk_we = 1'b0; pa_we = 1'b0; sn_we = 1'b0; sc_we = 1'b0;
    tg_re = 1'b0; lk_re = 1'b0; hd_re = 1'b0; tl_re = 1'b0;
    mk_re = 1'b0; pa_re = 1'b0; sn_re = 1'b0; sc_re = 1'b0;
    tg_wa = '0; lk_wa = '0; tg_ra = '0;
    hd_wa = '0; tl_wa = '0; mk_wa = '0; pa_wa = '0; sn_wa = '0; sc_wa = '0;
    hd_ra = '0; tl_ra = '0; mk_ra = '0; pa_ra = '0; sn_ra = '0;
    tg_wd = '0; pa_wd = '0; sn_wd = '0;
    lk_wd = '0; hd_wd = '0; tl_wd = '0; sc_wd = '0;
    mk_wd = MARK_UNVISITED;
    unique case (op)
      OP_CLR: begin
        mk_we = 1'b1; mk_wa = clr_idx_r;
        pa_we = 1'b1; pa_wa = clr_idx_r;
        hd_we = clr_edges_r; hd_wa = clr_idx_r; hd_wd = NIL_SLOT;
        tl_we = clr_edges_r; tl_wa = clr_idx_r; tl_wd = NIL_SLOT;
      end
      OP_SCAN_RD: begin
        mk_re = 1'b1; mk_ra = sweep_r[NODE_W-1:0];
      end
      OP_START_RD: begin
        hd_re = 1'b1; hd_ra = sweep_r[NODE_W-1:0];
      end
      OP_START_WR: begin
        mk_we = 1'b1; mk_wa = sweep_r[NODE_W-1:0]; mk_wd = MARK_EXPLORED;
        sn_we = 1'b1; sn_wa = push_idx; sn_wd = sweep_r[NODE_W-1:0];
        sc_we = 1'b1; sc_wa = push_idx; sc_wd = hd_q;
      end
      OP_TOP_RD: begin
        sn_re = 1'b1; sc_re = 1'b1; sn_ra = top_idx;
      end
      OP_TOP: begin
        if (status.cur_nil) begin
          mk_we = 1'b1; mk_wa = sn_q; mk_wd = MARK_FINISHED;
        end else begin
          tg_re = 1'b1; lk_re = 1'b1; tg_ra = sc_q[SAW-1:0];
          pa_re = 1'b1; pa_ra = sn_q;
        end
      end
      OP_EDGE: begin
        sc_we = 1'b1; sc_wa = top_idx; sc_wd = lk_q;
        mk_re = 1'b1; mk_ra = tg_q;
        hd_re = 1'b1; hd_ra = tg_q;
      end
      OP_CLASSIFY: begin
        if (push_ok) begin
          pa_we = 1'b1; pa_wa = n_r; pa_wd = s_r;
          mk_we = 1'b1; mk_wa = n_r; mk_wd = MARK_EXPLORED;
          sn_we = 1'b1; sn_wa = push_idx; sn_wd = n_r;
          sc_we = 1'b1; sc_wa = push_idx; sc_wd = hd_q;
        end
      end
      OP_LD_RD: begin
        tl_re = 1'b1; tl_ra = end_node;
      end
      OP_LD_W1: begin
        tg_we = 1'b1; tg_wa = slot_a; tg_wd = other_node;
        lk_we = 1'b1; lk_wa = slot_a; lk_wd = NIL_SLOT;
        tl_we = 1'b1; tl_wa = end_node; tl_wd = slot_v;
        hd_we = tail_nil; hd_wa = end_node; hd_wd = slot_v;
      end
      OP_LD_W2: begin
        lk_we = !tail_nil; lk_wa = tl_q[SAW-1:0]; lk_wd = slot_v;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tg_we) tg_mem[tg_wa] <= tg_wd;
    if (tg_re) tg_q <= tg_mem[tg_ra];
    if (lk_we) lk_mem[lk_wa] <= lk_wd;
    if (lk_re) lk_q <= lk_mem[tg_ra];
    if (hd_we) hd_mem[hd_wa] <= hd_wd;
    if (hd_re) hd_q <= hd_mem[hd_ra];
    if (tl_we) tl_mem[tl_wa] <= tl_wd;
    if (tl_re) tl_q <= tl_mem[tl_ra];
    if (mk_we) mk_mem[mk_wa] <= mk_wd;
    if (mk_re) mk_q <= mk_mem[mk_ra];
    if (pa_we) pa_mem[pa_wa] <= pa_wd;
    if (pa_re) pa_q <= pa_mem[pa_ra];
    if (sn_we) sn_mem[sn_wa] <= sn_wd;
    if (sn_re) sn_q <= sn_mem[sn_ra];
    if (sc_we) sc_mem[sc_wa] <= sc_wd;
    if (sc_re) sc_q <= sc_mem[sn_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_CNT_RST;
      depth_r      <= '0;
      sweep_r      <= '0;
      comp_r       <= '0;
      fill_r       <= '0;
      clr_idx_r    <= '0;
      clr_edges_r  <= 1'b1;
      side_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count_r <= cfg_node_count;
      end
      unique case (op)
        OP_ACCEPT: begin
          act_r  <= act_t'(in_action);
          a_r    <= in_node_a;
          b_r    <= in_node_b;
          side_r <= 1'b0;
        end
        OP_BEGIN: begin
          if (act_r == ACT_LOAD) begin
            kind_r <= status.bad_load ? KIND_REJECT : KIND_ACK;
            from_r <= a_r;
            to_r   <= b_r;
          end else if (act_r != ACT_STEP) begin
            kind_r      <= KIND_ACK;
            from_r      <= '0;
            to_r        <= '0;
            depth_r     <= '0;
            sweep_r     <= '0;
            comp_r      <= '0;
            clr_idx_r   <= '0;
            clr_edges_r <= act_r == ACT_CLEAR;
            if (act_r == ACT_CLEAR) begin
              fill_r <= '0;
            end
          end
        end
        OP_CLR: clr_idx_r <= clr_idx_r + NODE_W'(1);
        OP_SCAN_NEXT: sweep_r <= sweep_r + CNT_W'(1);
        OP_DONE: begin
          sweep_r <= eff_cnt;
          kind_r  <= KIND_DONE;
          from_r  <= '0;
          to_r    <= '0;
        end
        OP_START_WR: begin
          depth_r <= depth_r + CNT_W'(1);
          sweep_r <= sweep_r + CNT_W'(1);
          comp_r  <= comp_r + CNT_W'(1);
          kind_r  <= KIND_START;
          from_r  <= sweep_r[NODE_W-1:0];
          to_r    <= '0;
        end
        OP_TOP: begin
          from_r <= sn_q;
          s_r    <= sn_q;
          if (status.cur_nil) begin
            depth_r <= depth_m1;
            kind_r  <= KIND_FINISH;
            to_r    <= '0;
          end
        end
        OP_EDGE: begin
          to_r <= tg_q;
          n_r  <= tg_q;
        end
        OP_CLASSIFY: begin
          if (push_ok) begin
            depth_r <= depth_r + CNT_W'(1);
            kind_r  <= KIND_TREE;
          end else if (mk_q == MARK_EXPLORED) begin
            kind_r <= (pa_q == n_r) ? KIND_PARENT : KIND_BACK;
          end else begin
            kind_r <= KIND_CROSS;
          end
        end
        OP_LD_W2: begin
          side_r <= ~side_r;
          if (side_r) begin
            fill_r <= fill_r + FW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= kind_r;
      out_from_r <= from_r;
      out_to_r   <= to_r;
      out_comp_r <= comp_r;
      out_done_r <= status.depth_zero && status.sweep_end;
    end
  end

  assign out_kind      = out_kind_r;
  assign out_from_node = out_from_r;
  assign out_to_node   = out_to_r;
  assign out_component = out_comp_r;
  assign out_walk_done = out_done_r;

endmodule

// ----- hw/rtl/dfs_ec_ctrl.sv -----
// ----------------------------------------------------------------------------
// DFS edge classifier controller
// Sequences loads, walk steps, clearing passes, sweeps and result transfer.
// ----------------------------------------------------------------------------
`include "dfs_edge_classifier_core_macros.svh"

module dfs_ec_ctrl
  import dfs_ec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_op_t     op,
  output logic       out_load
);

  ctrl_state_t state_r, state_nxt;
  logic        pend_r, pend_nxt;
  logic        ctx_r, ctx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pend_r      <= 1'b0;
      ctx_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      ctx_r       <= ctx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    ctx_nxt       = ctx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = OP_NONE;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        op = OP_CLR;
        if (status.clr_last) begin
          state_nxt = pend_r ? ST_POST : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = OP_ACCEPT;
          state_nxt = ST_BEGIN;
        end
      end
      ST_BEGIN: begin
        op = OP_BEGIN;
        unique case (status.act)
          ACT_LOAD: state_nxt = status.bad_load ? ST_POST : ST_LD_RD;
          ACT_STEP: begin
            if (status.depth_zero) begin
              ctx_nxt   = 1'b1;
              state_nxt = ST_SCAN_RD;
            end else begin
              state_nxt = ST_TOP_RD;
            end
          end
          ACT_RESTART, ACT_CLEAR: begin
            pend_nxt  = 1'b1;
            state_nxt = ST_CLEAR;
          end
          default: state_nxt = ST_POST;
        endcase
      end
      ST_SCAN_RD: begin
        if (status.sweep_end) begin
          if (ctx_r) begin
            op        = OP_DONE;
            state_nxt = ST_POST;
          end else begin
            state_nxt = ST_OUT;
          end
        end else begin
          op        = OP_SCAN_RD;
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (status.mark_zero) begin
          state_nxt = ctx_r ? ST_START_RD : ST_OUT;
        end else begin
          op        = OP_SCAN_NEXT;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_START_RD: begin
        op        = OP_START_RD;
        state_nxt = ST_START_WR;
      end
      ST_START_WR: begin
        op        = OP_START_WR;
        state_nxt = ST_POST;
      end
      ST_TOP_RD: begin
        op        = OP_TOP_RD;
        state_nxt = ST_TOP;
      end
      ST_TOP: begin
        op        = OP_TOP;
        state_nxt = status.cur_nil ? ST_POST : ST_EDGE;
      end
      ST_EDGE: begin
        op        = OP_EDGE;
        state_nxt = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        op        = OP_CLASSIFY;
        state_nxt = ST_POST;
      end
      ST_LD_RD: begin
        op        = OP_LD_RD;
        state_nxt = ST_LD_W1;
      end
      ST_LD_W1: begin
        op        = OP_LD_W1;
        state_nxt = ST_LD_W2;
      end
      ST_LD_W2: begin
        op        = OP_LD_W2;
        state_nxt = status.side ? ST_POST : ST_LD_RD;
      end
      ST_POST: begin
        ctx_nxt   = 1'b0;
        state_nxt = status.depth_zero ? ST_SCAN_RD : ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `DFS_EC_ASSERT_HOLDS(a_top_nonempty, clk, rst_n, state_r == ST_TOP_RD, !status.depth_zero, "stack top read with empty stack")
  `DFS_EC_ASSERT_HOLDS(a_scan_in_range, clk, rst_n, state_r == ST_SCAN_CHK, !status.sweep_end, "sweep mark checked past node count")
  `DFS_EC_ASSERT_NEXT(a_clear_ends, clk, rst_n, state_r == ST_CLEAR && status.clr_last, state_r != ST_CLEAR, "clearing pass overran")
  `DFS_EC_ASSERT_NEXT(a_out_loaded, clk, rst_n, state_r == ST_OUT && out_free, out_valid_r && state_r == ST_IDLE, "result not presented after load")

endmodule

// ----- hw/rtl/dfs_edge_classifier_core.sv -----
// ----------------------------------------------------------------------------
// DFS edge classifier core
// Undirected edge store with a stepped depth-first walk that classifies edges.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one command per transfer: load edge, step walk, restart walk,
//   or clear all edges. Every command yields exactly one result transfer on
//   out_if (kind, nodes, component number, walk_done).
//   cfg_if writes node_count; write it only while no command is in flight.
// Sequencing (one command at a time):
//   load and step work through the one-port list, mark and stack memories
//   in turn; when the stack is empty the mark memory is swept over already
//   visited nodes, so a step or command may also include that sweep.
//   restart and clear run a clearing pass over all 1024 node-store entries.
// Reset: a full clearing pass runs first; in_if.ready stays low during it.
// Stall: a finished result waits in the output register while the next command
//   is accepted and worked; the core holds before the next result until the
//   waiting one transfers.
// ----------------------------------------------------------------------------
module dfs_edge_classifier_core
  import dfs_ec_pkg::*;
#(
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input logic          clk,
  input logic          rst_n,
  dfs_ec_in_if.sink    in_if,
  dfs_ec_out_if.source out_if,
  dfs_ec_cfg_if.sink   cfg_if
);

  dp_op_t     op;
  dp_status_t status;
  logic       out_load;

  assign cfg_if.ready = 1'b1;

  dfs_ec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .op        (op),
    .out_load  (out_load)
  );

  dfs_ec_datapath #(
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .status         (status),
    .in_action      (in_if.action),
    .in_node_a      (in_if.node_a),
    .in_node_b      (in_if.node_b),
    .cfg_we         (cfg_if.valid),
    .cfg_node_count (cfg_if.node_count),
    .out_load       (out_load),
    .out_kind       (out_if.kind),
    .out_from_node  (out_if.from_node),
    .out_to_node    (out_if.to_node),
    .out_component  (out_if.component),
    .out_walk_done  (out_if.walk_done)
  );

endmodule

// ----- dv/tb_dfs_edge_classifier_core.sv -----
// ----------------------------------------------------------------------------
// DFS edge classifier core testbench
// Drives load, step, restart and clear commands through the valid/ready
// channels. A behavioral walk model predicts each result unless a typed
// directed row gives it; results are compared field by field. Directed
// rows first, then random graph phases under three idle/stall profiles.
// ----------------------------------------------------------------------------
module tb_dfs_edge_classifier_core;
  import dfs_ec_pkg::*;

  localparam int          SLOT_N = 2 * DEF_MAX_EDGES;
  localparam logic [12:0] NIL    = 13'(SLOT_N);
  localparam int          N_RAND = 550;

  typedef struct {
    kind_t             kind;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [CNT_W-1:0]  component;
    logic              walk_done;
  } dfs_result_t;

  typedef struct {
    bit                is_cfg;
    logic [CNT_W-1:0]  cfg_val;
    act_t              act;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    bit                typed;
    dfs_result_t       res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dfs_ec_in_if  in_if ();
  dfs_ec_out_if out_if ();
  dfs_ec_cfg_if cfg_if ();

  dfs_edge_classifier_core u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always #2 clk = ~clk;

  // walk model state
  logic [NODE_W-1:0] m_target [SLOT_N];
  logic [12:0]       m_link   [SLOT_N];
  logic [12:0]       m_head   [MAX_NODES];
  logic [12:0]       m_tail   [MAX_NODES];
  mark_t             m_mark   [MAX_NODES];
  logic [NODE_W-1:0] m_parent [MAX_NODES];
  logic [NODE_W-1:0] m_stk_n  [MAX_NODES];
  logic [12:0]       m_stk_c  [MAX_NODES];
  logic [CNT_W-1:0]  m_depth;
  logic [CNT_W-1:0]  m_sweep;
  logic [CNT_W-1:0]  m_comp;
  logic [12:0]       m_fill;
  logic [CNT_W-1:0]  m_count;

  dfs_result_t result_q[$];
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  int          n_err = 0;
  int          n_cmd = 0;
  int          n_res = 0;
  int          n_cfg = 0;
  int          kind_seen[16];

  function automatic logic [CNT_W-1:0] eff_count();
    return (m_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : m_count;
  endfunction

  function automatic void walk_restart();
    for (int i = 0; i < MAX_NODES; i++) begin
      m_mark[i]   = MARK_UNVISITED;
      m_parent[i] = '0;
    end
    m_depth = '0;
    m_sweep = '0;
    m_comp  = '0;
  endfunction

  function automatic void edges_clear();
    for (int i = 0; i < MAX_NODES; i++) begin
      m_head[i] = NIL;
      m_tail[i] = NIL;
    end
    m_fill = '0;
  endfunction

  function automatic void slot_append(logic [NODE_W-1:0] f, logic [NODE_W-1:0] t,
                                      logic [12:0] slot);
    m_target[slot] = t;
    m_link[slot]   = NIL;
    if (m_tail[f] == NIL) begin
      m_head[f] = slot;
    end else begin
      m_link[m_tail[f]] = slot;
    end
    m_tail[f] = slot;
  endfunction

  function automatic logic walk_finished();
    if (m_depth != 0) return 1'b0;
    for (int i = m_sweep; i < eff_count(); i++)
      if (m_mark[i] == MARK_UNVISITED) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void node_push(logic [NODE_W-1:0] n);
    m_mark[n]        = MARK_EXPLORED;
    m_stk_n[m_depth] = n;
    m_stk_c[m_depth] = m_head[n];
    m_depth++;
  endfunction

  function automatic void walk_advance(ref dfs_result_t r);
    logic [CNT_W-1:0]  cnt;
    logic [CNT_W-1:0]  top;
    logic [NODE_W-1:0] s;
    logic [NODE_W-1:0] n;
    logic [12:0]       cur;
    cnt = eff_count();
    if (m_depth == 0) begin
      while (m_sweep < cnt && m_mark[m_sweep] != MARK_UNVISITED) m_sweep++;
      if (m_sweep >= cnt) begin
        m_sweep = cnt;
        r.kind = KIND_DONE;
        return;
      end
      s = m_sweep[NODE_W-1:0];
      m_sweep++;
      m_comp++;
      node_push(s);
      r.from_node = s;
      r.kind = KIND_START;
      return;
    end
    top = m_depth - 1'b1;
    s   = m_stk_n[top];
    cur = m_stk_c[top];
    r.from_node = s;
    if (cur == NIL) begin
      m_mark[s] = MARK_FINISHED;
      m_depth   = top;
      r.kind    = KIND_FINISH;
      return;
    end
    n = m_target[cur];
    m_stk_c[top] = m_link[cur];
    r.to_node = n;
    if (m_mark[n] == MARK_UNVISITED) begin
      m_parent[n] = s;
      node_push(n);
      r.kind = KIND_TREE;
    end else if (m_mark[n] == MARK_EXPLORED) begin
      r.kind = (m_parent[s] == n) ? KIND_PARENT : KIND_BACK;
    end else begin
      r.kind = KIND_CROSS;
    end
  endfunction

  function automatic dfs_result_t predict_cmd(act_t act, logic [NODE_W-1:0] a,
                                              logic [NODE_W-1:0] b);
    dfs_result_t r;
    r = '{KIND_ACK, '0, '0, '0, 1'b0};
    case (act)
      ACT_LOAD: begin
        r.from_node = a;
        r.to_node   = b;
        if (a >= eff_count() || b >= eff_count() || m_fill >= DEF_MAX_EDGES) begin
          r.kind = KIND_REJECT;
        end else begin
          slot_append(a, b, {m_fill[11:0], 1'b0});
          slot_append(b, a, {m_fill[11:0], 1'b1});
          m_fill++;
        end
      end
      ACT_STEP: walk_advance(r);
      ACT_RESTART: walk_restart();
      default: begin
        edges_clear();
        walk_restart();
      end
    endcase
    r.component = m_comp;
    r.walk_done = walk_finished();
    return r;
  endfunction

  task automatic report_mismatch(string what);
    n_err++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic send_cmd(act_t act, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                          bit typed = 0, dfs_result_t want = '{KIND_ACK, '0, '0, '0, 1'b0});
    dfs_result_t r;
    if ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_if.valid  <= 1'b1;
    in_if.action <= act;
    in_if.node_a <= a;
    in_if.node_b <= b;
    do @(posedge clk); while (!in_if.ready);
    r = predict_cmd(act, a, b);
    result_q = {result_q, (typed ? want : r)};
    n_cmd++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] v);
    drain();
    cfg_if.valid      <= 1'b1;
    cfg_if.node_count <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    m_count = v;
    n_cfg++;
  endtask

  always @(posedge clk) begin
    out_if.ready <= (!rst_n) ? 1'b1 : ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    dfs_result_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_res++;
      kind_seen[out_if.kind]++;
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", out_if.kind));
      end else begin
        w = result_q.pop_front();
        if (out_if.kind !== w.kind || out_if.from_node !== w.from_node ||
            out_if.to_node !== w.to_node || out_if.component !== w.component ||
            out_if.walk_done !== w.walk_done)
          report_mismatch($sformatf(
            "got k%0d %0d->%0d c%0d d%0d, want k%0d %0d->%0d c%0d d%0d",
            out_if.kind, out_if.from_node, out_if.to_node, out_if.component,
            out_if.walk_done, w.kind, w.from_node, w.to_node, w.component,
            w.walk_done));
      end
    end
  end

  function automatic dir_row_t cmd_row(act_t act, int a, int b);
    dir_row_t d;
    d = '{0, '0, act, NODE_W'(a), NODE_W'(b), 0, '{KIND_ACK, '0, '0, '0, 1'b0}};
    return d;
  endfunction

  function automatic dir_row_t typed_row(act_t act, int a, int b, kind_t k, int f,
                                         int t, int c, bit dn);
    dir_row_t d;
    d = cmd_row(act, a, b);
    d.typed = 1;
    d.res = '{k, NODE_W'(f), NODE_W'(t), CNT_W'(c), dn};
    return d;
  endfunction

  function automatic dir_row_t cfg_row(int v);
    dir_row_t d;
    d = cmd_row(ACT_LOAD, 0, 0);
    d.is_cfg = 1;
    d.cfg_val = CNT_W'(v);
    return d;
  endfunction

  task automatic rand_load(int cnt);
    if (cnt == 0 || $urandom_range(9) == 0)
      send_cmd(ACT_LOAD, NODE_W'($urandom_range(1023)), NODE_W'($urandom_range(1023)));
    else
      send_cmd(ACT_LOAD, NODE_W'($urandom_range(cnt - 1)),
               NODE_W'($urandom_range(cnt - 1)));
  endtask

  task automatic rand_phase(ref int budget);
    int cnt_opts[12] = '{1, 2, 3, 4, 5, 6, 8, 10, 12, 16, 1024, 0};
    logic [CNT_W-1:0] c;
    int cnt, n_loads, n_steps, extra;
    c = CNT_W'(cnt_opts[$urandom_range(11)]);
    if (c == 1024 && $urandom_range(1)) c = CNT_W'(2047 - $urandom_range(1000));
    write_count(c);
    cnt = eff_count();
    if ($urandom_range(1)) send_cmd(ACT_CLEAR, '0, '0);
    else send_cmd(ACT_RESTART, NODE_W'($urandom), NODE_W'($urandom));
    n_loads = (cnt >= 1024) ? $urandom_range(4, 12) : $urandom_range(0, 2 * cnt + 2);
    if (n_loads > budget - 2) n_loads = (budget > 2) ? budget - 2 : 0;
    for (int i = 0; i < n_loads; i++) rand_load(cnt);
    n_steps = 0;
    extra = $urandom_range(1, 3);
    while (n_steps < ((cnt >= 1024) ? 40 : 200) && extra > 0 &&
           n_loads + n_steps + 1 < budget) begin
      case ($urandom_range(19))
        0: rand_load(cnt);
        1: if ($urandom_range(3) == 0) send_cmd(ACT_RESTART, '0, '0);
        default: send_cmd(ACT_STEP, NODE_W'($urandom), NODE_W'($urandom));
      endcase
      n_steps++;
      if (walk_finished()) extra--;
    end
    budget -= n_loads + n_steps + 1;
  endtask

  initial begin
    dir_row_t rows[$];
    int budget;
    in_if.valid = 1'b0;
    in_if.action = ACT_LOAD;
    in_if.node_a = '0;
    in_if.node_b = '0;
    cfg_if.valid = 1'b0;
    cfg_if.node_count = '0;
    m_count = NODE_CNT_RST;
    edges_clear();
    walk_restart();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    rows = {rows, cfg_row(4)};
    rows = {rows, typed_row(ACT_CLEAR, 0, 0, KIND_ACK, 0, 0, 0, 0)};
    rows = {rows, typed_row(ACT_LOAD, 0, 1, KIND_ACK, 0, 1, 0, 0)};
    rows = {rows, typed_row(ACT_LOAD, 1, 1, KIND_ACK, 1, 1, 0, 0)};
    rows = {rows, typed_row(ACT_LOAD, 0, 0, KIND_ACK, 0, 0, 0, 0)};
    rows = {rows, typed_row(ACT_LOAD, 4, 0, KIND_REJECT, 4, 0, 0, 0)};
    rows = {rows, typed_row(ACT_LOAD, 1023, 1023, KIND_REJECT, 1023, 1023, 0, 0)};
    rows = {rows, typed_row(ACT_LOAD, 2, 3, KIND_ACK, 2, 3, 0, 0)};
    rows = {rows, typed_row(ACT_STEP, 0, 0, KIND_START, 0, 0, 1, 0)};
    for (int i = 0; i < 6; i++) rows = {rows, cmd_row(ACT_STEP, 0, 0)};
    rows = {rows, cmd_row(ACT_LOAD, 3, 0)};
    for (int i = 0; i < 9; i++) rows = {rows, cmd_row(ACT_STEP, 0, 0)};
    rows = {rows, typed_row(ACT_RESTART, 0, 0, KIND_ACK, 0, 0, 0, 0)};
    rows = {rows, cfg_row(0)};
    rows = {rows, typed_row(ACT_CLEAR, 0, 0, KIND_ACK, 0, 0, 0, 1)};
    rows = {rows, typed_row(ACT_LOAD, 0, 0, KIND_REJECT, 0, 0, 0, 1)};
    rows = {rows, typed_row(ACT_STEP, 0, 0, KIND_DONE, 0, 0, 0, 1)};
    rows = {rows, cfg_row(2047)};
    rows = {rows, typed_row(ACT_STEP, 0, 0, KIND_START, 0, 0, 1, 0)};
    rows = {rows, cmd_row(ACT_STEP, 0, 0)};
    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_count(rows[i].cfg_val);
      else send_cmd(rows[i].act, rows[i].a, rows[i].b, rows[i].typed, rows[i].res);
    end

    for (int mode = 0; mode < 3; mode++) begin
      src_idle_pct  = (mode == 0) ? 6 : (mode == 1) ? 47 : 0;
      snk_stall_pct = (mode == 0) ? 47 : (mode == 1) ? 6 : 0;
      budget = N_RAND / 3;
      while (budget > 0) begin
        rand_phase(budget);
        if (mode == 1 && budget < N_RAND / 6 && budget > 0) begin
          drain();
          send_cmd(ACT_STEP, '0, '0);
          budget--;
        end
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("Ran %0d commands, %0d results checked, %0d node-count writes.",
             n_cmd, n_res, n_cfg);
    $display("Kinds seen: start %0d tree %0d back %0d parent %0d cross %0d reject %0d",
             kind_seen[KIND_START], kind_seen[KIND_TREE], kind_seen[KIND_BACK],
             kind_seen[KIND_PARENT], kind_seen[KIND_CROSS], kind_seen[KIND_REJECT]);
    if (n_err == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout");
    $display("Regression FAIL");
    $finish;
  end

endmodule
